// ----- rtl/pse_pkg.sv -----
package pse_pkg;

  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned DEPTH_W     = $clog2(STACK_DEPTH + 1);

  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned TOP_W       = 32;
  localparam int unsigned OUT_DEPTH_W = 5;
  localparam int unsigned DIGIT_W     = 4;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_PLUS = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_STAR = 8'h2A;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_ADD  = 2'd1,
    OP_MUL  = 2'd2,
    OP_NOP  = 2'd3
  } op_kind_e;

  typedef struct packed {
    op_kind_e           kind;
    logic [DIGIT_W-1:0] digit;
  } op_t;

  // sign extend or truncate a stack value to the output width
  function automatic logic [TOP_W-1:0] to_top(logic [VALUE_WIDTH-1:0] v);
    logic [63:0] ext;
    ext = 64'(signed'(v));
    return ext[TOP_W-1:0];
  endfunction

endpackage

// ----- rtl/pse_if.sv -----
interface pse_char_if;
  logic                        valid;
  logic                        ready;
  logic [pse_pkg::CHAR_W-1:0]  char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

interface pse_result_if;
  logic                             valid;
  logic                             ready;
  logic signed [pse_pkg::TOP_W-1:0] top_value;
  logic [pse_pkg::OUT_DEPTH_W-1:0]  stack_depth;
  logic                             underflow;
  logic                             overflow;
  logic                             ignored;

  modport source (output valid, output top_value, output stack_depth, output underflow,
                  output overflow, output ignored, input ready);
  modport sink   (input valid, input top_value, input stack_depth, input underflow,
                  input overflow, input ignored, output ready);
endinterface

// ----- rtl/postfix_stack_evaluator_core.sv -----
// Postfix evaluator: one ASCII character per request on char_i, one result per request on
// result_o. Digits push 0..9, '+' and '*' pop two and push the wrapping 32-bit result, an
// empty pop reads as -1 and sets underflow, a digit on a full 16-entry stack is dropped
// with overflow, anything else is flagged ignored. Throughput is one request per cycle while
// result_o does not stall, set by the update of the top two stack entries and the 32x32 multiplier in
// the execute stage; an accepted request passes through the decode queue and then the registered
// execute stage, whose result is held while result_o stalls. Requests are decoded into
// a two-entry queue so input and output stall independently.
module postfix_stack_evaluator_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  pse_char_if.sink      char_i,
  pse_result_if.source  result_o
);

  logic         fr_valid, fr_ready;
  pse_pkg::op_t fr_op;
  logic         bk_valid, bk_ready;
  pse_pkg::op_t bk_op;

  pse_front u_front (
    .char_i       (char_i),
    .push_valid_o (fr_valid),
    .push_ready_i (fr_ready),
    .push_op_o    (fr_op)
  );

  pse_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_op_i    (fr_op),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_op_o     (bk_op)
  );

  pse_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (bk_valid),
    .op_ready_o (bk_ready),
    .op_i       (bk_op),
    .result_o   (result_o)
  );

endmodule

// ----- rtl/pse_front.sv -----
module pse_front (
  pse_char_if.sink        char_i,
  output logic            push_valid_o,
  input  logic            push_ready_i,
  output pse_pkg::op_t    push_op_o
);

  always_comb begin
    push_op_o.digit = '0;
    if (char_i.char_code inside {[pse_pkg::CHAR_ZERO:pse_pkg::CHAR_NINE]}) begin
      push_op_o.kind  = pse_pkg::OP_PUSH;
      push_op_o.digit = pse_pkg::DIGIT_W'(char_i.char_code - pse_pkg::CHAR_ZERO);
    end else if (char_i.char_code == pse_pkg::CHAR_PLUS) begin
      push_op_o.kind = pse_pkg::OP_ADD;
    end else if (char_i.char_code == pse_pkg::CHAR_STAR) begin
      push_op_o.kind = pse_pkg::OP_MUL;
    end else begin
      push_op_o.kind = pse_pkg::OP_NOP;
    end
  end

  assign push_valid_o = char_i.valid;
  assign char_i.ready = push_ready_i;

endmodule

// ----- rtl/pse_queue.sv -----
module pse_queue (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_valid_i,
  output logic         push_ready_o,
  input  pse_pkg::op_t push_op_i,
  output logic         pop_valid_o,
  input  logic         pop_ready_i,
  output pse_pkg::op_t pop_op_o
);

  pse_pkg::op_t                    mem_q [pse_pkg::QUEUE_DEPTH];
  logic [pse_pkg::QUEUE_AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [pse_pkg::QUEUE_AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [pse_pkg::QUEUE_CW-1:0]    count_q, count_d;
  logic                            do_push, do_pop;

  assign push_ready_o = count_q != pse_pkg::QUEUE_CW'(pse_pkg::QUEUE_DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign pop_op_o     = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == pse_pkg::QUEUE_AW'(pse_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                             : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == pse_pkg::QUEUE_AW'(pse_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                             : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_op_i;
    end
  end

endmodule

// ----- rtl/pse_back.sv -----
module pse_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            op_valid_i,
  output logic            op_ready_o,
  input  pse_pkg::op_t    op_i,
  pse_result_if.source    result_o
);

  localparam int unsigned VW = pse_pkg::VALUE_WIDTH;
  localparam int unsigned DW = pse_pkg::DEPTH_W;

  logic [VW-1:0]                   stack_q [pse_pkg::STACK_DEPTH];
  logic [DW-1:0]                   depth_q, depth_d;
  logic                            out_valid_q, out_valid_d;
  logic [pse_pkg::TOP_W-1:0]       out_top_q;
  logic [pse_pkg::OUT_DEPTH_W-1:0] out_depth_q;
  logic                            out_under_q, out_over_q, out_ign_q;

  logic          exec, full, is_op;
  logic [VW-1:0] opa, opb, sum, prod, res, top_d;
  logic          under, over, ign;

  assign op_ready_o = !out_valid_q || result_o.ready;
  assign exec       = op_valid_i && op_ready_o;
  assign full       = depth_q == DW'(pse_pkg::STACK_DEPTH);
  assign is_op      = (op_i.kind == pse_pkg::OP_ADD) || (op_i.kind == pse_pkg::OP_MUL);

  // empty pops read as all ones
  assign opa  = (depth_q != '0) ? stack_q[0] : '1;
  assign opb  = (depth_q > DW'(1)) ? stack_q[1] : '1;
  assign sum  = opa + opb;
  assign prod = opa * opb;
  assign res  = (op_i.kind == pse_pkg::OP_ADD) ? sum : prod;

  always_comb begin
    depth_d = depth_q;
    top_d   = stack_q[0];
    under   = 1'b0;
    over    = 1'b0;
    ign     = 1'b0;
    case (op_i.kind)
      pse_pkg::OP_PUSH: begin
        if (full) begin
          over = 1'b1;
        end else begin
          depth_d = depth_q + 1'b1;
          top_d   = VW'(op_i.digit);
        end
      end
      pse_pkg::OP_ADD, pse_pkg::OP_MUL: begin
        under   = depth_q < DW'(2);
        depth_d = (depth_q < DW'(2)) ? DW'(1) : depth_q - 1'b1;
        top_d   = res;
      end
      default: begin
        ign = 1'b1;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (exec) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (exec) begin
        depth_q <= depth_d;
      end
    end
  end

  // stack as a shift line, entry 0 is the top
  always_ff @(posedge clk_i) begin
    if (exec) begin
      if (op_i.kind == pse_pkg::OP_PUSH && !full) begin
        stack_q[0] <= top_d;
        for (int i = 1; i < pse_pkg::STACK_DEPTH; i++) begin
          stack_q[i] <= stack_q[i-1];
        end
      end else if (is_op) begin
        stack_q[0] <= top_d;
        for (int i = 1; i < pse_pkg::STACK_DEPTH - 1; i++) begin
          stack_q[i] <= stack_q[i+1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      out_top_q   <= (depth_d == '0) ? '0 : pse_pkg::to_top(top_d);
      out_depth_q <= pse_pkg::OUT_DEPTH_W'(depth_d);
      out_under_q <= under;
      out_over_q  <= over;
      out_ign_q   <= ign;
    end
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.top_value   = out_top_q;
  assign result_o.stack_depth = out_depth_q;
  assign result_o.underflow   = out_under_q;
  assign result_o.overflow    = out_over_q;
  assign result_o.ignored     = out_ign_q;

  ap_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DW'(pse_pkg::STACK_DEPTH))
    else $error("stack depth beyond capacity");

  ap_over_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec && op_i.kind == pse_pkg::OP_PUSH && full |=> depth_q == DW'(pse_pkg::STACK_DEPTH))
    else $error("dropped digit changed the depth");

  ap_op_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec && is_op |=> depth_q != '0)
    else $error("operator left the stack empty");

  ap_under_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_under_q |-> out_depth_q == pse_pkg::OUT_DEPTH_W'(1))
    else $error("underflow with depth other than one");

  ap_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_ign_q |-> !out_under_q && !out_over_q)
    else $error("ignored request carries a stack flag");

  ap_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !result_o.ready |=> out_valid_q && $stable(out_top_q))
    else $error("stalled result lost");

endmodule
